/* src/slip_pkg.sv */
// Shared types and constants for the SLIP frame decoder.
package slip_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_LEN = 3'd0,
    CFG_END     = 3'd1,
    CFG_ESC     = 3'd2,
    CFG_ESC_END = 3'd3,
    CFG_ESC_ESC = 3'd4
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd255;
  localparam logic [BYTE_W-1:0] END_RESET     = 8'd192;
  localparam logic [BYTE_W-1:0] ESC_RESET     = 8'd219;
  localparam logic [BYTE_W-1:0] ESC_END_RESET = 8'd220;
  localparam logic [BYTE_W-1:0] ESC_ESC_RESET = 8'd221;

  typedef struct packed {
    logic [BYTE_W-1:0] max_frame_len;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] esc_code;
    logic [BYTE_W-1:0] esc_end_code;
    logic [BYTE_W-1:0] esc_esc_code;
  } cfg_t;

  typedef struct packed {
    logic              escape_pending;
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic [BYTE_W-1:0] stored_count;
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_last;
    logic [BYTE_W-1:0] frame_length;
  } result_t;

endpackage

/* src/slip_frame_decoder_core.sv */
// Top level of the SLIP frame decoder: input register, decode state, result register.
//
// Usage:
//   Raw line bytes enter on rx_byte with in_valid/in_ready; decoded payload
//   bytes leave on data_byte/frame_last/frame_length with out_valid/out_ready.
//   The user writes registers via cfg_write/cfg_index/cfg_data only while idle, and
//   the block does not enforce it. Each decoded byte is held until the next stored
//   byte or the END delimiter releases it, so a byte's request appears only after
//   its successor arrives; the last byte of a frame carries frame_last and the frame length.
//   Decode: a taken byte waits in the input register until the result register
//   can take its output, and any result it releases is offered from then on.
//   Throughput: one byte per cycle while no result stalls on out_ready, set by
//   the combinational decode between the input register and the result register.
//   Reset: clears both registers, the escape and held-byte state and the
//   count, and loads the register defaults (END 0xC0, ESC 0xDB, ESC_END 0xDC,
//   ESC_ESC 0xDD, max length 255).
//   Stall: while a result waits on out_ready, one more byte is taken into the
//   input register; then in_ready drops until the result is taken.
module slip_frame_decoder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [slip_pkg::BYTE_W-1:0]      rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [slip_pkg::BYTE_W-1:0]      data_byte,
  output logic                             frame_last,
  output logic [slip_pkg::BYTE_W-1:0]      frame_length,
  input  logic                             cfg_write,
  input  logic [slip_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slip_pkg::BYTE_W-1:0]      cfg_data
);
  import slip_pkg::*;

  cfg_t              cfg;
  state_t            state;
  state_t            state_next;
  result_t           step_result;
  result_t           result;
  logic              step_emit;
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;

  slip_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slip_step u_step (
    .cfg        (cfg),
    .state      (state),
    .rx_byte    (in_byte),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  // Decode the buffered byte once the result register can take its output.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      result <= step_result;
    end
  end

  assign data_byte    = result.data_byte;
  assign frame_last   = result.frame_last;
  assign frame_length = result.frame_length;

endmodule

/* src/slip_cfg_regs.sv */
// Configuration register file for the SLIP frame decoder.
module slip_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [slip_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slip_pkg::BYTE_W-1:0]      cfg_data,
  output slip_pkg::cfg_t                   cfg
);
  import slip_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_frame_len <= MAX_LEN_RESET;
      cfg.end_code      <= END_RESET;
      cfg.esc_code      <= ESC_RESET;
      cfg.esc_end_code  <= ESC_END_RESET;
      cfg.esc_esc_code  <= ESC_ESC_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_LEN: cfg.max_frame_len <= cfg_data;
        CFG_END:     cfg.end_code      <= cfg_data;
        CFG_ESC:     cfg.esc_code      <= cfg_data;
        CFG_ESC_END: cfg.esc_end_code  <= cfg_data;
        CFG_ESC_ESC: cfg.esc_esc_code  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/slip_step.sv */
// Per-byte decode logic: escape handling, length limit and held-byte release.
module slip_step (
  input  slip_pkg::cfg_t              cfg,
  input  slip_pkg::state_t            state,
  input  logic [slip_pkg::BYTE_W-1:0] rx_byte,
  output slip_pkg::state_t            state_next,
  output logic                        emit,
  output slip_pkg::result_t           result
);
  import slip_pkg::*;

  logic [BYTE_W-1:0] decoded;
  logic              do_store;
  logic              room;

  // Undo an escape; any other byte after ESC passes through as is.
  always_comb begin
    if (rx_byte == cfg.esc_end_code) begin
      decoded = cfg.end_code;
    end else if (rx_byte == cfg.esc_esc_code) begin
      decoded = cfg.esc_code;
    end else begin
      decoded = rx_byte;
    end
  end

  assign room = (state.stored_count < cfg.max_frame_len);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    do_store   = 1'b0;
    result     = '{data_byte: state.held_byte, frame_last: 1'b0, frame_length: '0};

    if (state.escape_pending) begin
      state_next.escape_pending = 1'b0;
      do_store = 1'b1;
    end else if (rx_byte == cfg.end_code) begin
      // Close the frame; an empty frame gives nothing.
      if (state.stored_count != '0 && state.held_valid) begin
        emit                = 1'b1;
        result.frame_last   = 1'b1;
        result.frame_length = state.stored_count;
      end
      state_next.held_valid   = 1'b0;
      state_next.stored_count = '0;
    end else if (rx_byte == cfg.esc_code) begin
      state_next.escape_pending = 1'b1;
    end else begin
      do_store = 1'b1;
    end

    // Store the byte and release the previous one; drop it past the limit.
    if (do_store && room) begin
      emit                    = state.held_valid;
      state_next.stored_count = state.stored_count + BYTE_W'(1);
      state_next.held_valid   = 1'b1;
      state_next.held_byte    = state.escape_pending ? decoded : rx_byte;
    end
  end

endmodule

/* src/slip_checker.sv */
// Port-level assertions for the SLIP frame decoder, bound to the top level.
module slip_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [slip_pkg::BYTE_W-1:0]      data_byte,
  input logic                             frame_last,
  input logic [slip_pkg::BYTE_W-1:0]      frame_length
);
  import slip_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) &&
                                $stable(frame_last) && $stable(frame_length))
    else $error("result changed while stalled");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> frame_length == '0)
    else $error("length set on a byte that does not end the frame");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> frame_length != '0)
    else $error("frame ended with zero length");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind slip_frame_decoder_core slip_checker u_slip_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .data_byte    (data_byte),
  .frame_last   (frame_last),
  .frame_length (frame_length)
);

/* tb/sv/tb_slip_frame_decoder_core.sv */
// Self-checking testbench for the SLIP frame decoder core.
`timescale 1ns / 100ps

module tb_slip_frame_decoder_core;
  import slip_pkg::*;

  localparam int RAND_ITEMS     = 1150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_PRINTS     = 40;
  localparam int QUIET_PHASE    = 4;

  localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_IDX = CFG_ESC_ESC + 3'd1;
  localparam logic [CFG_INDEX_W-1:0] LAST_SPARE_IDX  = '1;

  typedef enum logic [0:0] {
    PLAN_BYTE,
    PLAN_CFG
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t             kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [BYTE_W-1:0]      value;      // line byte or register data
    logic                   typed;      // expectation written into the plan
    logic                   typed_any;
    result_t                typed_res;
  } plan_row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      rx_byte   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [BYTE_W-1:0]      data_byte;
  logic                   frame_last;
  logic [BYTE_W-1:0]      frame_length;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]      cfg_data  = '0;

  slip_frame_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .frame_last   (frame_last),
    .frame_length (frame_length),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  cfg_t      dec_cfg;
  state_t    dec_st;
  result_t   pending_bytes[$];
  result_t   seen_exp;
  plan_row_t plan[$];
  int        mismatches   = 0;
  int        items_sent   = 0;
  int        stall_cycles = 0;
  bit        quiet        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit keep_byte(input logic [BYTE_W-1:0] c, output result_t res);
    bit emit;
    emit = 1'b0;
    res  = '0;
    if (dec_st.stored_count >= dec_cfg.max_frame_len) return 1'b0;
    dec_st.stored_count = dec_st.stored_count + 8'd1;
    if (dec_st.held_valid) begin
      res.data_byte = dec_st.held_byte;
      emit = 1'b1;
    end
    dec_st.held_byte  = c;
    dec_st.held_valid = 1'b1;
    return emit;
  endfunction

  function automatic bit decode_step(input logic [BYTE_W-1:0] rx, output result_t res);
    logic [BYTE_W-1:0] c;
    bit                emit;
    c    = rx;
    emit = 1'b0;
    res  = '0;
    if (dec_st.escape_pending) begin
      dec_st.escape_pending = 1'b0;
      if (c == dec_cfg.esc_end_code) c = dec_cfg.end_code;
      else if (c == dec_cfg.esc_esc_code) c = dec_cfg.esc_code;
      emit = keep_byte(c, res);
    end else if (c == dec_cfg.end_code) begin
      if (dec_st.stored_count != '0 && dec_st.held_valid) begin
        res.data_byte    = dec_st.held_byte;
        res.frame_last   = 1'b1;
        res.frame_length = dec_st.stored_count;
        emit = 1'b1;
      end
      dec_st.held_valid   = 1'b0;
      dec_st.stored_count = '0;
    end else if (c == dec_cfg.esc_code) begin
      dec_st.escape_pending = 1'b1;
    end else begin
      emit = keep_byte(c, res);
    end
    return emit;
  endfunction

  // ---------------------------------------------------------------- plan rows

  function automatic plan_row_t raw_row(input logic [BYTE_W-1:0] b);
    plan_row_t r;
    r       = '0;
    r.kind  = PLAN_BYTE;
    r.value = b;
    return r;
  endfunction

  function automatic plan_row_t none_row(input logic [BYTE_W-1:0] b);
    plan_row_t r;
    r       = raw_row(b);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t exp_row(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] d,
                                        input logic l, input logic [BYTE_W-1:0] n);
    plan_row_t r;
    r                        = none_row(b);
    r.typed_any              = 1'b1;
    r.typed_res.data_byte    = d;
    r.typed_res.frame_last   = l;
    r.typed_res.frame_length = n;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] v);
    plan_row_t r;
    r         = '0;
    r.kind    = PLAN_CFG;
    r.reg_idx = idx;
    r.value   = v;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Called and left right after a falling edge.
  task automatic send_byte(input plan_row_t r);
    result_t res;
    bit      emit;
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= r.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    emit = decode_step(r.value, res);
    if (r.typed) begin
      if (r.typed_any) pending_bytes.push_back(r.typed_res);
    end else if (emit) begin
      pending_bytes.push_back(res);
    end
    @(negedge clk);
  endtask

  // Hold the sender until every expected byte is out and the pipe is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_MAX_LEN: dec_cfg.max_frame_len = val;
      CFG_END:     dec_cfg.end_code      = val;
      CFG_ESC:     dec_cfg.esc_code      = val;
      CFG_ESC_END: dec_cfg.esc_end_code  = val;
      CFG_ESC_ESC: dec_cfg.esc_esc_code  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [BYTE_W-1:0] m, e, s, se, ss;
    case ($urandom_range(0, 4))
      0:       m = 8'd1;
      1:       m = MAX_LEN_RESET;
      2:       m = BYTE_W'($urandom_range(2, 6));
      3:       m = BYTE_W'($urandom_range(7, 24));
      default: m = BYTE_W'($urandom_range(1, 255));
    endcase
    e  = END_RESET;
    s  = ESC_RESET;
    se = ESC_END_RESET;
    ss = ESC_ESC_RESET;
    case ($urandom_range(0, 4))
      1: begin
        e  = BYTE_W'($urandom_range(0, 255));
        s  = BYTE_W'($urandom_range(0, 255));
        se = BYTE_W'($urandom_range(0, 255));
        ss = BYTE_W'($urandom_range(0, 255));
      end
      2: begin
        // collide two codes to exercise the priority order
        e  = BYTE_W'($urandom_range(0, 255));
        s  = $urandom_range(0, 1) ? e : BYTE_W'($urandom_range(0, 255));
        se = BYTE_W'($urandom_range(0, 255));
        ss = $urandom_range(0, 1) ? se : BYTE_W'($urandom_range(0, 255));
      end
      3: begin
        e  = 8'h00;
        s  = 8'hFF;
        se = 8'h01;
        ss = 8'hFE;
      end
      default: ;
    endcase
    write_reg(CFG_MAX_LEN, m);
    write_reg(CFG_END, e);
    write_reg(CFG_ESC, s);
    write_reg(CFG_ESC_END, se);
    write_reg(CFG_ESC_ESC, ss);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_INDEX_W'($urandom_range(FIRST_SPARE_IDX, LAST_SPARE_IDX)),
                BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_frame();
    int                len;
    logic [BYTE_W-1:0] d;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 270) : $urandom_range(1, 12);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0:       d = dec_cfg.end_code;
        1:       d = dec_cfg.esc_code;
        2:       d = dec_cfg.esc_end_code;
        3:       d = dec_cfg.esc_esc_code;
        default: d = BYTE_W'($urandom_range(0, 255));
      endcase
      if (d == dec_cfg.end_code) begin
        send_byte(raw_row(dec_cfg.esc_code));
        send_byte(raw_row(dec_cfg.esc_end_code));
      end else if (d == dec_cfg.esc_code) begin
        send_byte(raw_row(dec_cfg.esc_code));
        send_byte(raw_row(dec_cfg.esc_esc_code));
      end else begin
        send_byte(raw_row(d));
      end
    end
    case ($urandom_range(0, 19))
      0: ;  // leave the frame open across the next settings change
      1: begin
        send_byte(raw_row(dec_cfg.esc_code));
        send_byte(raw_row(BYTE_W'($urandom_range(0, 255))));
        send_byte(raw_row(dec_cfg.end_code));
      end
      default: send_byte(raw_row(dec_cfg.end_code));
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(negedge clk) out_ready <= quiet || ($urandom_range(0, 99) >= 10);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last=%0b len=%0d",
                                  data_byte, frame_last, frame_length));
      end else begin
        seen_exp = pending_bytes.pop_front();
        if (data_byte !== seen_exp.data_byte)
          report_mismatch($sformatf("data_byte %02h, expected %02h",
                                    data_byte, seen_exp.data_byte));
        if (frame_last !== seen_exp.frame_last)
          report_mismatch($sformatf("frame_last %0b, expected %0b",
                                    frame_last, seen_exp.frame_last));
        if (frame_length !== seen_exp.frame_length)
          report_mismatch($sformatf("frame_length %0d, expected %0d",
                                    frame_length, seen_exp.frame_length));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_slip_frame_decoder_core: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase;
    int target;
    dec_cfg.max_frame_len = MAX_LEN_RESET;
    dec_cfg.end_code      = END_RESET;
    dec_cfg.esc_code      = ESC_RESET;
    dec_cfg.esc_end_code  = ESC_END_RESET;
    dec_cfg.esc_esc_code  = ESC_ESC_RESET;
    dec_st                = '0;

    // reset codes: END C0, ESC DB, ESC_END DC, ESC_ESC DD
    plan.push_back(none_row(END_RESET));                        // empty frame dropped
    plan.push_back(none_row(8'h00));
    plan.push_back(exp_row(8'hFF, 8'h00, 1'b0, 8'd0));
    plan.push_back(none_row(ESC_RESET));
    plan.push_back(exp_row(ESC_END_RESET, 8'hFF, 1'b0, 8'd0));
    plan.push_back(none_row(ESC_RESET));
    plan.push_back(exp_row(ESC_ESC_RESET, END_RESET, 1'b0, 8'd0));
    plan.push_back(none_row(ESC_RESET));
    plan.push_back(exp_row(END_RESET, ESC_RESET, 1'b0, 8'd0));  // END after escape is data
    plan.push_back(exp_row(8'h55, END_RESET, 1'b0, 8'd0));
    plan.push_back(exp_row(END_RESET, 8'h55, 1'b1, 8'd6));
    plan.push_back(none_row(END_RESET));
    plan.push_back(none_row(ESC_RESET));
    plan.push_back(none_row(ESC_RESET));                        // plain byte after escape
    plan.push_back(exp_row(END_RESET, ESC_RESET, 1'b1, 8'd1));
    // truncation at one byte, and a write to an unused index
    plan.push_back(cfg_row(CFG_MAX_LEN, 8'd1));
    plan.push_back(cfg_row(FIRST_SPARE_IDX, 8'h00));
    plan.push_back(none_row(8'h11));
    plan.push_back(none_row(8'h22));
    plan.push_back(exp_row(END_RESET, 8'h11, 1'b1, 8'd1));
    // zero length keeps nothing
    plan.push_back(cfg_row(CFG_MAX_LEN, 8'd0));
    plan.push_back(none_row(8'h33));
    plan.push_back(none_row(END_RESET));
    // END and ESC share a code, and so do the two escape codes
    plan.push_back(cfg_row(CFG_MAX_LEN, MAX_LEN_RESET));
    plan.push_back(cfg_row(CFG_END, 8'h7E));
    plan.push_back(cfg_row(CFG_ESC, 8'h7E));
    plan.push_back(cfg_row(CFG_ESC_END, 8'h5E));
    plan.push_back(cfg_row(CFG_ESC_ESC, 8'h5E));
    plan.push_back(raw_row(8'h7E));
    plan.push_back(raw_row(8'h41));
    plan.push_back(raw_row(8'h7E));
    plan.push_back(cfg_row(CFG_ESC, 8'h7D));
    plan.push_back(raw_row(8'h7D));
    plan.push_back(raw_row(8'h5E));
    plan.push_back(raw_row(8'h7E));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_CFG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_byte(plan[i]);
      end
    end

    phase = 0;
    while (items_sent < RAND_ITEMS) begin
      quiet = (phase == QUIET_PHASE);
      drain();
      pick_settings();
      target = items_sent + $urandom_range(40, 100);
      while (items_sent < target) begin
        if ($urandom_range(0, 29) == 0) drain();
        if ($urandom_range(0, 14) == 0)
          send_byte(raw_row($urandom_range(0, 1) ? dec_cfg.end_code
                                                 : BYTE_W'($urandom_range(0, 255))));
        send_frame();
      end
      phase++;
    end
    quiet = 1'b0;

    drain();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_slip_frame_decoder_core: done, clean");
    end else begin
      $display("tb_slip_frame_decoder_core: done, errors");
    end
    $finish;
  end

endmodule
